@@ hw/rtl/char_lcd_cursor_sequencer_top_assert.svh @@
// assertion macros used by the top-level rtl file
`ifndef CHAR_LCD_CURSOR_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_CURSOR_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CLCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clcs assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define CLCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clcs assertion failed");

`endif

@@ hw/rtl/clcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_pkg
// Types and constants of the character lcd cursor sequencer.
// ----------------------------------------------------------------------------
package clcs_pkg;

  localparam int unsigned COLUMNS_DEF = 16;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WAIT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 3'd0,
    FUNC_CLEAR = 3'd1,
    FUNC_HOME  = 3'd2,
    FUNC_CON   = 3'd3,
    FUNC_COFF  = 3'd4,
    FUNC_INIT  = 3'd5
  } func_e;

  localparam logic [WAIT_W-1:0] WAIT_FAST  = 2'd0;
  localparam logic [WAIT_W-1:0] WAIT_SLOW  = 2'd1;
  localparam logic [WAIT_W-1:0] WAIT_START = 2'd2;

  localparam logic [BYTE_W-1:0] CMD_HOME_ROW0 = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_HOME_ROW1 = 8'hC0;
  localparam logic [BYTE_W-1:0] CMD_LEFT      = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_RIGHT     = 8'h14;
  localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_HOME      = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_FUNCSET   = 8'h3C;
  localparam logic [BYTE_W-1:0] CMD_CUR_OFF   = 8'h0C;
  localparam logic [BYTE_W-1:0] CMD_CUR_ON    = 8'h0E;
  localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;

  localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;

  localparam int unsigned OPS_BS    = 3;
  localparam int unsigned OPS_CLEAR = 2;
  localparam int unsigned OPS_INIT  = 5;

endpackage

@@ hw/rtl/clcs_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_in_if
// Text operation channel: valid, ready and one operation per beat.
// ----------------------------------------------------------------------------
interface clcs_in_if;
  logic                        valid;
  logic                        ready;
  logic [clcs_pkg::FUNC_W-1:0] func;
  logic [clcs_pkg::BYTE_W-1:0] char_code;

  modport source (output valid, output func, output char_code, input ready);
  modport sink   (input valid, input func, input char_code, output ready);
endinterface

@@ hw/rtl/clcs_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcs_out_if
// Lcd bus write channel: valid, ready and one bus write per beat.
// ----------------------------------------------------------------------------
interface clcs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        reg_select;
  logic [clcs_pkg::BYTE_W-1:0] bus_byte;
  logic [clcs_pkg::WAIT_W-1:0] wait_class;
  logic                        last;

  modport source (output valid, output reg_select, output bus_byte, output wait_class,
                  output last, input ready);
  modport sink   (input valid, input reg_select, input bus_byte, input wait_class,
                  input last, output ready);
endinterface

@@ hw/rtl/char_lcd_cursor_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_sequencer_top
// Text operation to character lcd bus write sequencer with cursor tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one text operation per beat (func, char_code). out_o
//   carries the lcd bus writes it causes, one per beat, with last set on
//   the final write of each operation. Unused func codes are taken and
//   cause no write.
//   An operation causes 1 to 2*COLUMNS+2 writes (34 at 16 columns). A
//   small sequencer produces one write per cycle while out_o is not
//   stalled, through a single column add/subtract unit; each write is
//   registered, and in_i.ready stays low until the final one is produced.
//   The next operation is taken while the final write still waits on out_o.
//   A stall on out_o.ready holds the output register and pauses the
//   sequencer; nothing is dropped.
//   Reset puts the cursor at row 0, column 0 and empties the output
//   register. Display power-up waits and pin timing are left to the
//   downstream bus driver, which reads wait_class.
// ----------------------------------------------------------------------------
module char_lcd_cursor_sequencer_top #(
  parameter int unsigned COLUMNS = clcs_pkg::COLUMNS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  clcs_in_if.sink           in_i,
  clcs_out_if.source        out_o
);
  import clcs_pkg::*;

  `include "char_lcd_cursor_sequencer_top_assert.svh"

  localparam int unsigned CW      = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
  localparam int unsigned MAX_OPS = (COLUMNS > OPS_INIT) ? COLUMNS : OPS_INIT;
  localparam int unsigned OW      = $clog2(MAX_OPS + 1);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  typedef enum logic [3:0] {
    M_CHAR, M_HOMEROW, M_LF_R, M_LF_L, M_BS, M_CLEAR, M_CON, M_COFF, M_INIT
  } mode_e;

  typedef enum logic [2:0] {K_RIGHT, K_LEFT, K_GLYPH, K_HOMEROW, K_CMD} kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] byte_val;
    logic [WAIT_W-1:0] wait_val;
    logic              clr;
  } op_t;

  function automatic op_t op_decode(mode_e mode, logic [2:0] step, logic [BYTE_W-1:0] ch);
    op_t op;
    op = '{kind: K_CMD, byte_val: CMD_CUR_OFF, wait_val: WAIT_FAST, clr: 1'b0};
    unique case (mode)
      M_CHAR: begin
        op.kind     = K_GLYPH;
        op.byte_val = ch;
      end
      M_HOMEROW: op.kind = K_HOMEROW;
      M_LF_R:    op.kind = K_RIGHT;
      M_LF_L:    op.kind = K_LEFT;
      M_BS: begin
        if (step == 3'd1) begin
          op.kind     = K_GLYPH;
          op.byte_val = CHR_SPACE;
        end else begin
          op.kind = K_LEFT;
        end
      end
      M_CLEAR: begin
        op.wait_val = WAIT_SLOW;
        op.byte_val = (step == 3'd0) ? CMD_CLEAR : CMD_HOME;
        op.clr      = (step != 3'd0);
      end
      M_CON:  op.byte_val = CMD_CUR_ON;
      M_COFF: op.byte_val = CMD_CUR_OFF;
      M_INIT: begin
        unique case (step)
          3'd0: begin
            op.byte_val = CMD_FUNCSET;
            op.wait_val = WAIT_START;
          end
          3'd1: op.byte_val = CMD_CUR_OFF;
          3'd2: op.byte_val = CMD_ENTRY;
          3'd3: begin
            op.byte_val = CMD_CLEAR;
            op.wait_val = WAIT_SLOW;
          end
          default: begin
            op.byte_val = CMD_HOME;
            op.wait_val = WAIT_SLOW;
            op.clr      = 1'b1;
          end
        endcase
      end
      default: op.kind = K_CMD;
    endcase
    return op;
  endfunction

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [2:0]        step_q, step_d;
  logic [OW-1:0]     outer_q, outer_d;
  logic [CW-1:0]     inner_q, inner_d;
  logic              pend_q, pend_d;
  logic              row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [BYTE_W-1:0] char_q, char_d;

  logic              out_valid_q, out_valid_d;
  logic              out_rs_q, out_rs_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic [WAIT_W-1:0] out_wait_q, out_wait_d;
  logic              out_last_q, out_last_d;

  logic              in_fire;
  logic              adv;
  logic              col_inc;
  logic [CW-1:0]     col_sum;
  logic              col_wrap;
  op_t               op;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign adv        = (state_q == S_RUN) && (!out_valid_q || out_o.ready);

  // shared column unit
  assign col_sum  = col_q + (col_inc ? CW'(1) : {CW{1'b1}});
  assign col_wrap = col_inc && (col_q == CW'(COLUMNS - 1));

  assign op = op_decode(mode_q, step_q, char_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    step_d      = step_q;
    outer_d     = outer_q;
    inner_d     = inner_q;
    pend_d      = pend_q;
    row_d       = row_q;
    col_d       = col_q;
    char_d      = char_q;
    col_inc     = 1'b1;
    out_valid_d = out_valid_q;
    out_rs_d    = out_rs_q;
    out_byte_d  = out_byte_q;
    out_wait_d  = out_wait_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      step_d = 3'd0;
      char_d = in_i.char_code;
      unique case (in_i.func)
        FUNC_PUT: begin
          priority if (in_i.char_code == CHR_CR) begin
            mode_d  = M_HOMEROW;
            outer_d = OW'(1);
          end else if (in_i.char_code == CHR_LF) begin
            mode_d  = row_q ? M_LF_L : M_LF_R;
            outer_d = OW'(COLUMNS);
          end else if (in_i.char_code == CHR_BS) begin
            mode_d  = M_BS;
            outer_d = OW'(OPS_BS);
          end else begin
            mode_d  = M_CHAR;
            outer_d = OW'(1);
          end
        end
        FUNC_CLEAR: begin
          mode_d  = M_CLEAR;
          outer_d = OW'(OPS_CLEAR);
        end
        FUNC_HOME: begin
          mode_d  = M_HOMEROW;
          outer_d = OW'(1);
        end
        FUNC_CON: begin
          mode_d  = M_CON;
          outer_d = OW'(1);
        end
        FUNC_COFF: begin
          mode_d  = M_COFF;
          outer_d = OW'(1);
        end
        FUNC_INIT: begin
          mode_d  = M_INIT;
          outer_d = OW'(OPS_INIT);
        end
        default: outer_d = '0;
      endcase
      state_d = (outer_d != '0) ? S_RUN : S_IDLE;
    end else if (adv) begin
      out_valid_d = 1'b1;
      out_rs_d    = 1'b0;
      out_wait_d  = WAIT_FAST;
      out_byte_d  = CMD_RIGHT;
      if (pend_q) begin
        out_byte_d = row_q ? CMD_HOME_ROW0 : CMD_HOME_ROW1;
        row_d      = ~row_q;
        pend_d     = 1'b0;
      end else if (inner_q != '0) begin
        col_d   = col_wrap ? '0 : col_sum;
        pend_d  = col_wrap;
        inner_d = inner_q - CW'(1);
      end else begin
        outer_d = outer_q - OW'(1);
        step_d  = step_q + 3'd1;
        unique case (op.kind)
          K_RIGHT: begin
            col_d  = col_wrap ? '0 : col_sum;
            pend_d = col_wrap;
          end
          K_LEFT: begin
            if (col_q == '0) begin
              out_byte_d = row_q ? CMD_HOME_ROW0 : CMD_HOME_ROW1;
              row_d      = ~row_q;
              inner_d    = CW'(COLUMNS - 1);
            end else begin
              col_inc    = 1'b0;
              out_byte_d = CMD_LEFT;
              col_d      = col_sum;
            end
          end
          K_GLYPH: begin
            out_rs_d   = 1'b1;
            out_byte_d = op.byte_val;
            col_d      = col_wrap ? '0 : col_sum;
            pend_d     = col_wrap;
          end
          K_HOMEROW: begin
            out_byte_d = row_q ? CMD_HOME_ROW1 : CMD_HOME_ROW0;
            col_d      = '0;
          end
          default: begin
            out_byte_d = op.byte_val;
            out_wait_d = op.wait_val;
            if (op.clr) begin
              row_d = 1'b0;
              col_d = '0;
            end
          end
        endcase
      end
      out_last_d = !(pend_d || (inner_d != '0) || (outer_d != '0));
      if (out_last_d) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_CHAR;
      step_q      <= '0;
      outer_q     <= '0;
      inner_q     <= '0;
      pend_q      <= 1'b0;
      row_q       <= 1'b0;
      col_q       <= '0;
      char_q      <= '0;
      out_valid_q <= 1'b0;
      out_rs_q    <= 1'b0;
      out_byte_q  <= '0;
      out_wait_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      step_q      <= step_d;
      outer_q     <= outer_d;
      inner_q     <= inner_d;
      pend_q      <= pend_d;
      row_q       <= row_d;
      col_q       <= col_d;
      char_q      <= char_d;
      out_valid_q <= out_valid_d;
      out_rs_q    <= out_rs_d;
      out_byte_q  <= out_byte_d;
      out_wait_q  <= out_wait_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.reg_select = out_rs_q;
  assign out_o.bus_byte   = out_byte_q;
  assign out_o.wait_class = out_wait_q;
  assign out_o.last       = out_last_q;

  `CLCS_ASSERT_IMP(a_col_range, 1'b1, col_q <= CW'(COLUMNS - 1))
  `CLCS_ASSERT_IMP(a_run_has_work, state_q == S_RUN,
                   pend_q || (inner_q != '0) || (outer_q != '0))
  `CLCS_ASSERT_IMP(a_inner_mode, inner_q != '0, (mode_q == M_LF_L) || (mode_q == M_BS))
  `CLCS_ASSERT_IMP(a_mid_beat_busy, out_valid_q && !out_last_q, state_q == S_RUN)
  `CLCS_ASSERT_NXT(a_beat_on_adv, adv, out_valid_q)

endmodule

@@ verif/char_lcd_cursor_sequencer_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_cursor_sequencer_top_test
// Self-checking bench: a queue-fed driver offers text operations, a cursor
// tracking predictor builds the lcd writes each one should cause, and a
// monitor with random and long back-pressure checks every write beat.
// ----------------------------------------------------------------------------
module char_lcd_cursor_sequencer_top_test;
  import clcs_pkg::*;

  localparam int unsigned COLS          = COLUMNS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
  localparam int unsigned RANDOM_OPS    = 420;
  localparam int unsigned DRAIN_AT      = 220;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned SETTLE_CYCLES = 2 * COLS + 10;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] char_code;
    int unsigned       gap;
    bit                drain_first;
  } text_op_t;

  typedef struct {
    logic              rs;
    logic [BYTE_W-1:0] data;
    logic [WAIT_W-1:0] wcls;
    logic              last;
  } lcd_write_t;

  logic clk_i;
  logic rst_ni;

  clcs_in_if  op_if ();
  clcs_out_if wr_if ();

  char_lcd_cursor_sequencer_top #(.COLUMNS(COLS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (wr_if)
  );

  text_op_t    pending_ops[$];
  lcd_write_t  lcd_writes[$];
  lcd_write_t  got_wr;
  lcd_write_t  want_wr;
  logic        cur_row;
  int unsigned cur_col;
  int unsigned ops_total;
  int unsigned ops_taken;
  int unsigned beats_seen;
  int unsigned recv_stall;
  int unsigned mismatches;
  logic        hold_off;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // cursor tracking predictor
  task automatic push_write(logic rs, logic [BYTE_W-1:0] data, logic [WAIT_W-1:0] wcls);
    lcd_write_t w;
    w.rs   = rs;
    w.data = data;
    w.wcls = wcls;
    w.last = 1'b0;
    lcd_writes.push_back(w);
  endtask

  task automatic home_other_row();
    push_write(1'b0, cur_row ? CMD_HOME_ROW0 : CMD_HOME_ROW1, WAIT_FAST);
    cur_row = ~cur_row;
  endtask

  task automatic home_this_row();
    push_write(1'b0, cur_row ? CMD_HOME_ROW1 : CMD_HOME_ROW0, WAIT_FAST);
    cur_col = 0;
  endtask

  task automatic step_column();
    cur_col++;
    if (cur_col >= COLS) begin
      cur_col = 0;
      home_other_row();
    end
  endtask

  task automatic move_right();
    push_write(1'b0, CMD_RIGHT, WAIT_FAST);
    step_column();
  endtask

  task automatic move_left();
    if (cur_col == 0) begin
      home_other_row();
      repeat (COLS - 1) move_right();
    end else begin
      cur_col--;
      push_write(1'b0, CMD_LEFT, WAIT_FAST);
    end
  endtask

  task automatic write_glyph(logic [BYTE_W-1:0] c);
    push_write(1'b1, c, WAIT_FAST);
    step_column();
  endtask

  task automatic clear_screen();
    push_write(1'b0, CMD_CLEAR, WAIT_SLOW);
    push_write(1'b0, CMD_HOME, WAIT_SLOW);
    cur_row = 1'b0;
    cur_col = 0;
  endtask

  task automatic predict_op(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] ch);
    int unsigned first;
    first = lcd_writes.size();
    case (func)
      FUNC_PUT: begin
        if (ch == CHR_CR) begin
          home_this_row();
        end else if (ch == CHR_LF) begin
          if (!cur_row) repeat (COLS) move_right();
          else repeat (COLS) move_left();
        end else if (ch == CHR_BS) begin
          move_left();
          write_glyph(CHR_SPACE);
          move_left();
        end else begin
          write_glyph(ch);
        end
      end
      FUNC_CLEAR: clear_screen();
      FUNC_HOME:  home_this_row();
      FUNC_CON:   push_write(1'b0, CMD_CUR_ON, WAIT_FAST);
      FUNC_COFF:  push_write(1'b0, CMD_CUR_OFF, WAIT_FAST);
      FUNC_INIT: begin
        push_write(1'b0, CMD_FUNCSET, WAIT_START);
        push_write(1'b0, CMD_CUR_OFF, WAIT_FAST);
        push_write(1'b0, CMD_ENTRY, WAIT_FAST);
        clear_screen();
      end
      default: ;
    endcase
    if (lcd_writes.size() > first) lcd_writes[lcd_writes.size() - 1].last = 1'b1;
  endtask

  function automatic int unsigned draw_idle(bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic queue_op(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] ch, bit quiet,
                          bit drain);
    text_op_t op;
    op.func        = func;
    op.char_code   = ch;
    op.gap         = draw_idle(quiet);
    op.drain_first = drain;
    pending_ops.push_back(op);
    ops_total++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_if.valid     <= 1'b0;
      op_if.func      <= FUNC_PUT;
      op_if.char_code <= '0;
      ops_taken = 0;
      cur_row   = 1'b0;
      cur_col   = 0;
    end else begin
      if (op_if.valid && op_if.ready) begin
        predict_op(op_if.func, op_if.char_code);
        ops_taken++;
      end
      if (!(op_if.valid && !op_if.ready)) begin
        if (pending_ops.size() == 0) begin
          op_if.valid <= 1'b0;
        end else if (pending_ops[0].gap != 0) begin
          pending_ops[0].gap = pending_ops[0].gap - 1;
          op_if.valid <= 1'b0;
        end else if (pending_ops[0].drain_first && lcd_writes.size() != 0) begin
          op_if.valid <= 1'b0;
        end else begin
          op_if.valid     <= 1'b1;
          op_if.func      <= pending_ops[0].func;
          op_if.char_code <= pending_ops[0].char_code;
          void'(pending_ops.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_if.ready <= 1'b0;
      recv_stall = 0;
      beats_seen = 0;
    end else begin
      if (wr_if.valid && wr_if.ready) begin
        got_wr.rs   = wr_if.reg_select;
        got_wr.data = wr_if.bus_byte;
        got_wr.wcls = wr_if.wait_class;
        got_wr.last = wr_if.last;
        if (lcd_writes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected beat: rs=%0d byte=%02h wait=%0d last=%0d",
                     got_wr.rs, got_wr.data, got_wr.wcls, got_wr.last);
        end else begin
          want_wr = lcd_writes.pop_front();
          if (got_wr.rs !== want_wr.rs || got_wr.data !== want_wr.data ||
              got_wr.wcls !== want_wr.wcls || got_wr.last !== want_wr.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("beat %0d: exp %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                       beats_seen, want_wr.rs, want_wr.data, want_wr.wcls, want_wr.last,
                       got_wr.rs, got_wr.data, got_wr.wcls, got_wr.last);
          end
        end
        beats_seen++;
        recv_stall = draw_idle((beats_seen / 150) % 3 == 1);
      end
      if (hold_off) begin
        wr_if.ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        wr_if.ready <= 1'b0;
      end else begin
        wr_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    wait (beats_seen >= HOLD_AFTER);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    int unsigned       n_rand;
    int unsigned       r;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] ch;
    bit                quiet;

    rst_ni     = 1'b0;
    ops_total  = 0;
    mismatches = 0;

    // directed
    queue_op(FUNC_INIT,  8'h00, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   8'h00, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   8'hFF, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   CHR_BS, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   CHR_CR, 1'b0, 1'b0);
    // backspace from column 0, row 0: longest sequence
    queue_op(FUNC_PUT,   CHR_BS, 1'b0, 1'b0);
    // glyph on the last column wraps to the other row
    queue_op(FUNC_PUT,   8'h41, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   CHR_LF, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   CHR_LF, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   CHR_LF, 1'b0, 1'b0);
    // backspace from column 0, row 1
    queue_op(FUNC_PUT,   CHR_BS, 1'b0, 1'b0);
    queue_op(FUNC_HOME,  8'hFF, 1'b0, 1'b0);
    queue_op(FUNC_CON,   8'h00, 1'b0, 1'b0);
    queue_op(FUNC_COFF,  8'hFF, 1'b0, 1'b0);
    queue_op(FUNC_RSVD6, 8'h00, 1'b0, 1'b0);
    queue_op(FUNC_RSVD7, 8'hFF, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   8'h7F, 1'b0, 1'b0);
    queue_op(FUNC_CLEAR, 8'h55, 1'b0, 1'b0);
    queue_op(FUNC_PUT,   8'h80, 1'b0, 1'b0);
    queue_op(FUNC_INIT,  8'hAA, 1'b0, 1'b0);

    // random
    n_rand = 0;
    while (n_rand < RANDOM_OPS) begin
      quiet = ((n_rand / 40) % 4 == 3);
      r  = $urandom_range(0, 99);
      ch = BYTE_W'($urandom_range(0, 255));
      if (r < 58) begin
        func = FUNC_PUT;
      end else if (r < 66) begin
        func = FUNC_PUT;
        ch   = CHR_CR;
      end else if (r < 74) begin
        func = FUNC_PUT;
        ch   = CHR_LF;
      end else if (r < 84) begin
        func = FUNC_PUT;
        ch   = CHR_BS;
      end else if (r < 87) begin
        func = FUNC_CLEAR;
      end else if (r < 90) begin
        func = FUNC_HOME;
      end else if (r < 93) begin
        func = FUNC_CON;
      end else if (r < 96) begin
        func = FUNC_COFF;
      end else if (r < 97) begin
        func = FUNC_INIT;
      end else begin
        func = $urandom_range(0, 1) ? FUNC_RSVD7 : FUNC_RSVD6;
      end
      queue_op(func, ch, quiet, n_rand == DRAIN_AT);
      if (func <= FUNC_INIT) n_rand++;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (ops_taken == ops_total);
    while (lcd_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (lcd_writes.size() != 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0d expected beats never arrived", lcd_writes.size());
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/clcs_pkg.sv
hw/rtl/clcs_in_if.sv
hw/rtl/clcs_out_if.sv
hw/rtl/char_lcd_cursor_sequencer_top.sv
verif/char_lcd_cursor_sequencer_top_test.sv
